/* rtl/ave_pkg.sv */
// Shared widths, register codes and control structs for the arrival
// variability estimator. No dependencies.
package ave_pkg;

  localparam int COUNT_W       = 32;
  localparam int SUM_W         = 32;
  localparam int SQUARE_W      = 64;
  localparam int FACTOR_PORT_W = 32;
  localparam int SHIFT_W       = 4;

  // Partial products of count times square sum, split at half the square sum width.
  localparam int SQ_HALF_W = SQUARE_W / 2;
  localparam int PP_W      = COUNT_W + SQ_HALF_W;
  localparam int PROD_W    = COUNT_W + SQUARE_W;
  localparam int SUM_SQ_W  = 2 * SUM_W;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FACTOR_MAX      = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_SHIFT = CFG_INDEX_W'(1);

  localparam logic [FACTOR_PORT_W-1:0] FACTOR_MAX_RESET = FACTOR_PORT_W'(1048576);
  localparam logic [SHIFT_W-1:0]       SHIFT_RESET      = SHIFT_W'(3);

  // Travels alongside each item from the front end to the smoothing stages.
  typedef struct packed {
    logic                     bypass;    // no samples: prior factor passes through
    logic                     sum_zero;  // raw factor is the clamp value
    logic [FACTOR_PORT_W-1:0] prev;
  } side_t;

  typedef struct packed {
    logic [FACTOR_PORT_W-1:0] factor_max;
    logic [SHIFT_W-1:0]       smoothing_shift;
  } cfg_t;

endpackage

/* rtl/ave_front.sv */
// Front end: partial products, divisor square and dividend assembly in two stages.
// Depends on ave_pkg.
module ave_front #(
  parameter int FRACTION_WIDTH = 16,
  parameter int DIVIDEND_WIDTH = 136,
  parameter int DIVISOR_WIDTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              enable,
  input  logic                              in_valid,
  input  logic [ave_pkg::COUNT_W-1:0]       sample_count,
  input  logic [ave_pkg::SUM_W-1:0]         interval_sum,
  input  logic [ave_pkg::SQUARE_W-1:0]      interval_square_sum,
  input  logic [ave_pkg::FACTOR_PORT_W-1:0] prior_factor,
  output logic                              out_valid,
  output ave_pkg::side_t                    out_side,
  output logic [DIVIDEND_WIDTH-1:0]         dividend,
  output logic [DIVISOR_WIDTH-1:0]          divisor
);
  import ave_pkg::*;

  logic                a_valid;
  side_t               a_side;
  logic [PP_W-1:0]     pp_lo;
  logic [PP_W-1:0]     pp_hi;
  logic [SUM_SQ_W-1:0] sum_sq;
  logic [PROD_W-1:0]   product;

  assign product = PROD_W'(pp_lo) + {pp_hi, {SQ_HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (enable) begin
      a_valid   <= in_valid;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      pp_lo           <= sample_count * interval_square_sum[SQ_HALF_W-1:0];
      pp_hi           <= sample_count * interval_square_sum[SQUARE_W-1:SQ_HALF_W];
      sum_sq          <= interval_sum * interval_sum;
      a_side.bypass   <= (sample_count == '0);
      a_side.sum_zero <= (interval_sum == '0);
      a_side.prev     <= prior_factor;
      // scale by 2^F, then keep the dividend width
      dividend        <= DIVIDEND_WIDTH'({product, {FRACTION_WIDTH{1'b0}}});
      divisor         <= DIVISOR_WIDTH'(sum_sq);
      out_side        <= a_side;
    end
  end

endmodule

/* rtl/ave_cell.sv */
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
// Depends on ave_pkg.
module ave_cell #(
  parameter int DIVIDEND_WIDTH = 136,
  parameter int DIVISOR_WIDTH  = 64,
  parameter int QUO_W          = 33
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      enable,
  input  logic                      in_valid,
  input  ave_pkg::side_t            in_side,
  input  logic [DIVIDEND_WIDTH-1:0] in_dividend,
  input  logic [DIVISOR_WIDTH-1:0]  in_rem,
  input  logic [DIVISOR_WIDTH-1:0]  in_divisor,
  input  logic [QUO_W-1:0]          in_quo,
  input  logic                      in_big,
  output logic                      out_valid,
  output ave_pkg::side_t            out_side,
  output logic [DIVIDEND_WIDTH-1:0] out_dividend,
  output logic [DIVISOR_WIDTH-1:0]  out_rem,
  output logic [DIVISOR_WIDTH-1:0]  out_divisor,
  output logic [QUO_W-1:0]          out_quo,
  output logic                      out_big
);
  import ave_pkg::*;

  logic [DIVISOR_WIDTH:0] trial;
  logic [DIVISOR_WIDTH:0] diff;
  logic                   fits;

  assign trial = {in_rem, in_dividend[DIVIDEND_WIDTH-1]};
  assign diff  = trial - {1'b0, in_divisor};
  assign fits  = (trial >= {1'b0, in_divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      out_side     <= in_side;
      out_dividend <= in_dividend << 1;
      out_rem      <= fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
      out_divisor  <= in_divisor;
      // keep a window of low quotient bits; anything shifted out marks it big
      out_quo      <= {in_quo[QUO_W-2:0], fits};
      out_big      <= in_big | in_quo[QUO_W-1];
    end
  end

endmodule

/* rtl/ave_smooth.sv */
// Back end: raw factor from the quotient, then the shift-based moving average
// and clamp over four stages. Depends on ave_pkg.
module ave_smooth #(
  parameter int FRACTION_WIDTH = 16,
  parameter int FACTOR_WIDTH   = 32,
  parameter int QUO_W          = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    enable,
  input  ave_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  input  ave_pkg::side_t          in_side,
  input  logic [QUO_W-1:0]        in_quo,
  input  logic                    in_big,
  output logic                    out_valid,
  output logic [FACTOR_WIDTH-1:0] out_factor
);
  import ave_pkg::*;

  localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << FRACTION_WIDTH;

  logic [FACTOR_WIDTH-1:0] max_w;
  logic [FACTOR_WIDTH-1:0] prev_in;
  logic [QUO_W-1:0]        excess;
  logic [FACTOR_WIDTH-1:0] raw_next;

  logic                    r_valid, r_bypass;
  logic [FACTOR_WIDTH-1:0] r_raw, r_prev;
  logic                    d_valid, d_bypass, d_up;
  logic [FACTOR_WIDTH-1:0] d_mag, d_prev;
  logic                    t_valid, t_bypass, t_up;
  logic [FACTOR_WIDTH-1:0] t_step, t_prev;

  logic [FACTOR_WIDTH-1:0] shifted;
  logic                    lost;
  logic [FACTOR_WIDTH-1:0] upd;

  assign max_w   = FACTOR_WIDTH'(cfg.factor_max);
  assign prev_in = FACTOR_WIDTH'(in_side.prev);
  assign excess  = in_quo - ONE;

  always_comb begin
    if (in_side.sum_zero || in_big) begin
      raw_next = max_w;
    end else if (in_quo <= ONE) begin
      raw_next = '0;
    end else if (excess >= QUO_W'(max_w)) begin
      raw_next = max_w;
    end else begin
      raw_next = FACTOR_WIDTH'(excess);
    end
  end

  // negative steps round toward minus infinity
  assign shifted = d_mag >> cfg.smoothing_shift;
  assign lost    = |(d_mag & ~({FACTOR_WIDTH{1'b1}} << cfg.smoothing_shift));
  assign upd     = t_up ? t_prev + t_step : t_prev - t_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      d_valid   <= 1'b0;
      t_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (enable) begin
      r_valid   <= in_valid;
      d_valid   <= r_valid;
      t_valid   <= d_valid;
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      r_raw    <= raw_next;
      r_prev   <= prev_in;
      r_bypass <= in_side.bypass;

      d_up     <= (r_raw >= r_prev);
      d_mag    <= (r_raw >= r_prev) ? r_raw - r_prev : r_prev - r_raw;
      d_prev   <= r_prev;
      d_bypass <= r_bypass;

      t_up     <= d_up;
      t_step   <= d_up ? shifted : shifted + FACTOR_WIDTH'(lost);
      t_prev   <= d_prev;
      t_bypass <= d_bypass;

      if (t_bypass) begin
        out_factor <= t_prev;
      end else begin
        out_factor <= (upd > max_w) ? max_w : upd;
      end
    end
  end

endmodule

/* rtl/arrival_variability_estimator.sv */
// Arrival variability estimator: smoothed squared coefficient of variation.
// Two front stages, one division cell per dividend bit, four smoothing stages
// and the output register. Throughput one item per cycle while update_stall is low;
// a skid entry takes up a stalled result.
// Reset empties the pipeline and restores factor_max and smoothing_shift.
module arrival_variability_estimator #(
  parameter int FRACTION_WIDTH = 16,
  parameter int FACTOR_WIDTH   = 32,
  parameter int DIVIDEND_WIDTH = 136,
  parameter int DIVISOR_WIDTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              update_valid,
  output logic                              update_stall,
  input  logic [ave_pkg::COUNT_W-1:0]       sample_count,
  input  logic [ave_pkg::SUM_W-1:0]         interval_sum,
  input  logic [ave_pkg::SQUARE_W-1:0]      interval_square_sum,
  input  logic [ave_pkg::FACTOR_PORT_W-1:0] prior_factor,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [ave_pkg::FACTOR_PORT_W-1:0] new_factor,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ave_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ave_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ave_pkg::*;

  // quotient window wide enough that anything above it saturates
  localparam int QUO_W = (FACTOR_WIDTH > FRACTION_WIDTH ? FACTOR_WIDTH : FRACTION_WIDTH) + 1;

  cfg_t cfg;
  logic advance;
  logic take;

  logic                      chain_valid    [DIVIDEND_WIDTH+1];
  side_t                     chain_side     [DIVIDEND_WIDTH+1];
  logic [DIVIDEND_WIDTH-1:0] chain_dividend [DIVIDEND_WIDTH+1];
  logic [DIVISOR_WIDTH-1:0]  chain_rem      [DIVIDEND_WIDTH+1];
  logic [DIVISOR_WIDTH-1:0]  chain_divisor  [DIVIDEND_WIDTH+1];
  logic [QUO_W-1:0]          chain_quo      [DIVIDEND_WIDTH+1];
  logic                      chain_big      [DIVIDEND_WIDTH+1];

  logic                       tail_valid;
  logic [FACTOR_WIDTH-1:0]    tail_factor;
  logic [FACTOR_PORT_W-1:0]   tail_word;
  logic                       skid_valid;
  logic [FACTOR_PORT_W-1:0]   skid_factor;

  assign cfg_ready    = 1'b1;
  assign advance      = !skid_valid;
  assign update_stall = skid_valid;
  assign take         = result_valid && !result_stall;
  assign tail_word    = FACTOR_PORT_W'(tail_factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.factor_max      <= FACTOR_MAX_RESET;
      cfg.smoothing_shift <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FACTOR_MAX:      cfg.factor_max      <= cfg_data[FACTOR_PORT_W-1:0];
        REG_SMOOTHING_SHIFT: cfg.smoothing_shift <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  ave_front #(
    .FRACTION_WIDTH (FRACTION_WIDTH),
    .DIVIDEND_WIDTH (DIVIDEND_WIDTH),
    .DIVISOR_WIDTH  (DIVISOR_WIDTH)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .enable              (advance),
    .in_valid            (update_valid),
    .sample_count        (sample_count),
    .interval_sum        (interval_sum),
    .interval_square_sum (interval_square_sum),
    .prior_factor        (prior_factor),
    .out_valid           (chain_valid[0]),
    .out_side            (chain_side[0]),
    .dividend            (chain_dividend[0]),
    .divisor             (chain_divisor[0])
  );

  assign chain_rem[0] = '0;
  assign chain_quo[0] = '0;
  assign chain_big[0] = 1'b0;

  for (genvar i = 0; i < DIVIDEND_WIDTH; i++) begin : g_cell
    ave_cell #(
      .DIVIDEND_WIDTH (DIVIDEND_WIDTH),
      .DIVISOR_WIDTH  (DIVISOR_WIDTH),
      .QUO_W          (QUO_W)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .enable       (advance),
      .in_valid     (chain_valid[i]),
      .in_side      (chain_side[i]),
      .in_dividend  (chain_dividend[i]),
      .in_rem       (chain_rem[i]),
      .in_divisor   (chain_divisor[i]),
      .in_quo       (chain_quo[i]),
      .in_big       (chain_big[i]),
      .out_valid    (chain_valid[i+1]),
      .out_side     (chain_side[i+1]),
      .out_dividend (chain_dividend[i+1]),
      .out_rem      (chain_rem[i+1]),
      .out_divisor  (chain_divisor[i+1]),
      .out_quo      (chain_quo[i+1]),
      .out_big      (chain_big[i+1])
    );
  end

  ave_smooth #(
    .FRACTION_WIDTH (FRACTION_WIDTH),
    .FACTOR_WIDTH   (FACTOR_WIDTH),
    .QUO_W          (QUO_W)
  ) u_smooth (
    .clk        (clk),
    .rst        (rst),
    .enable     (advance),
    .cfg        (cfg),
    .in_valid   (chain_valid[DIVIDEND_WIDTH]),
    .in_side    (chain_side[DIVIDEND_WIDTH]),
    .in_quo     (chain_quo[DIVIDEND_WIDTH]),
    .in_big     (chain_big[DIVIDEND_WIDTH]),
    .out_valid  (tail_valid),
    .out_factor (tail_factor)
  );

  // Output register plus one skid entry; the pipeline holds while the skid is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (advance) begin
      if (!result_valid || take) begin
        result_valid <= tail_valid;
      end else if (tail_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!result_valid || take) begin
        new_factor <= tail_word;
      end else begin
        skid_factor <= tail_word;
      end
    end else if (take) begin
      new_factor <= skid_factor;
    end
  end

  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry held without a result in the output register");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && result_stall))
    else $error("skid entry filled while the output register was free");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result_stall |=> !skid_valid && result_valid)
    else $error("skid entry not moved to the output register when taken");

endmodule

/* sim/arrival_variability_estimator_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for arrival_variability_estimator: random and directed window
// statistics, random input gaps and result stalls, factor prediction checked per item.
// Depends on ave_pkg and the estimator RTL.
module arrival_variability_estimator_tb;
  import ave_pkg::*;

  localparam int FRACTION_BITS = 16;
  localparam int DIVIDEND_W    = 136;
  localparam int DIVISOR_W     = 64;
  localparam int PIPE_LATENCY  = DIVIDEND_W + 7;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_ITEMS   = 275;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_SMOOTHING_SHIFT + 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]       count;
    logic [SUM_W-1:0]         total;
    logic [SQUARE_W-1:0]      squares;
    logic [FACTOR_PORT_W-1:0] prior;
  } window_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     update_valid = 1'b0;
  logic                     update_stall;
  logic [COUNT_W-1:0]       sample_count = '0;
  logic [SUM_W-1:0]         interval_sum = '0;
  logic [SQUARE_W-1:0]      interval_square_sum = '0;
  logic [FACTOR_PORT_W-1:0] prior_factor = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic [FACTOR_PORT_W-1:0] new_factor;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // Bench copy of the register file
  logic [FACTOR_PORT_W-1:0] cfg_factor_max = FACTOR_MAX_RESET;
  logic [SHIFT_W-1:0]       cfg_shift = SHIFT_RESET;

  window_t                  pending_window_q[$];
  logic [FACTOR_PORT_W-1:0] expected_factor_q[$];
  window_t                  on_port;
  logic [FACTOR_PORT_W-1:0] wanted_factor;
  int                       idle_percent = 20;
  int                       send_gap = 0;
  int                       stall_left = 0;
  int                       result_count = 0;
  int                       error_count = 0;
  int                       cycle_count = 0;

  arrival_variability_estimator #(
    .FRACTION_WIDTH(FRACTION_BITS),
    .FACTOR_WIDTH  (FACTOR_PORT_W),
    .DIVIDEND_WIDTH(DIVIDEND_W),
    .DIVISOR_WIDTH (DIVISOR_W)
  ) u_dut (
    .clk                (clk),
    .rst                (rst),
    .update_valid       (update_valid),
    .update_stall       (update_stall),
    .sample_count       (sample_count),
    .interval_sum       (interval_sum),
    .interval_square_sum(interval_square_sum),
    .prior_factor       (prior_factor),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .new_factor         (new_factor),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Squared coefficient of variation in Q format, smoothed towards the prior factor.
  function automatic logic [FACTOR_PORT_W-1:0] predict_factor(window_t w);
    logic [PROD_W-1:0]        product;
    logic [DIVISOR_W-1:0]     sum_square;
    logic [DIVIDEND_W-1:0]    dividend, quotient, unity;
    logic [FACTOR_PORT_W:0]   prior, target, span, decrement, updated, limit, mask;
    prior = {1'b0, w.prior};
    limit = {1'b0, cfg_factor_max};
    if (w.count == '0) return w.prior;
    if (w.total == '0) begin
      target = limit;
    end else begin
      product    = PROD_W'(w.count) * PROD_W'(w.squares);
      sum_square = DIVISOR_W'(w.total) * DIVISOR_W'(w.total);
      dividend   = DIVIDEND_W'(product) << FRACTION_BITS;
      quotient   = dividend / DIVIDEND_W'(sum_square);
      unity      = DIVIDEND_W'(1) << FRACTION_BITS;
      if (quotient <= unity) target = '0;
      else if (quotient - unity >= DIVIDEND_W'(cfg_factor_max)) target = limit;
      else target = (FACTOR_PORT_W + 1)'(quotient - unity);
    end
    if (target >= prior) begin
      updated = prior + ((target - prior) >> cfg_shift);
    end else begin
      // round the decrement up so the average steps towards minus infinity
      span      = prior - target;
      mask      = ((FACTOR_PORT_W + 1)'(1) << cfg_shift) - 1'b1;
      decrement = (span >> cfg_shift) + (FACTOR_PORT_W + 1)'(|(span & mask));
      updated   = prior - decrement;
    end
    if (updated > limit) updated = limit;
    return updated[FACTOR_PORT_W-1:0];
  endfunction

  function automatic window_t make_window();
    window_t     w;
    int unsigned n, pick, hi;
    logic [63:0] s, q, x, lo_iv, hi_iv, base;
    pick      = $urandom_range(0, 99);
    s         = '0;
    q         = '0;
    w.count   = $urandom;
    w.total   = $urandom;
    w.squares = {$urandom, $urandom};
    if (pick < 70) begin
      // consistent statistics drawn from an actual interval pattern
      n = $urandom_range(1, 40);
      case ($urandom_range(0, 4))
        0: begin
          x = $urandom_range(1, 1 << 20);
          s = n * x;
          q = n * x * x;
        end
        1: begin
          lo_iv = $urandom_range(1, 4096);
          hi_iv = lo_iv + $urandom_range(0, 4096);
          for (int i = 0; i < n; i++) begin
            x = $urandom_range(lo_iv, hi_iv);
            s += x;
            q += x * x;
          end
        end
        2: begin
          for (int i = 0; i < n; i++) begin
            x = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 4);
            s += x;
            q += x * x;
          end
        end
        3: begin
          n  = $urandom_range(1, 65535);
          hi = 32'hFFFF_FFFF / n;
          if (hi > (1 << 20)) hi = 1 << 20;
          x    = $urandom_range(1, hi);
          s    = n * x;
          base = n * x * x;
          q    = base + (base >> $urandom_range(0, 12)) * $urandom_range(0, 4);
        end
        default: begin
          n = $urandom_range(1, 2);
          for (int i = 0; i < n; i++) begin
            x = $urandom_range(1, 32'h7FFF_FFFF);
            s += x;
            q += x * x;
          end
        end
      endcase
      w.count   = n;
      w.total   = s[SUM_W-1:0];
      w.squares = q;
    end else if (pick < 85) begin
      // statistics that no real window produces
      case ($urandom_range(0, 3))
        0: w.total = '0;
        1: begin
          w.count   = $urandom_range(1, 64);
          w.total   = $urandom_range(1, 1 << 24);
          w.squares = $urandom_range(0, 1 << 16);
        end
        2: w.count = '0;
        default: begin
          w.total   = $urandom_range(1, 255);
          w.squares = {$urandom | 32'h8000_0000, $urandom};
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1:    w.prior = $urandom;
      2, 3:    w.prior = $urandom_range(0, cfg_factor_max);
      4:       w.prior = cfg_factor_max;
      5:       w.prior = '0;
      default: w.prior = $urandom_range(0, 1 << 20);
    endcase
    return w;
  endfunction

  task automatic add_window(input logic [COUNT_W-1:0] n, input logic [SUM_W-1:0] s,
                            input logic [SQUARE_W-1:0] q, input logic [FACTOR_PORT_W-1:0] p);
    window_t w;
    w.count   = n;
    w.total   = s;
    w.squares = q;
    w.prior   = p;
    pending_window_q.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [FACTOR_PORT_W-1:0] got,
                                 input logic [FACTOR_PORT_W-1:0] wanted);
    $display("ERROR result %0d: %s, new_factor %h, expected %h",
             result_count, what, got, wanted);
    error_count++;
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_FACTOR_MAX:      cfg_factor_max = data[FACTOR_PORT_W-1:0];
      REG_SMOOTHING_SHIFT: cfg_shift = data[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every queued item has been taken and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (pending_window_q.size() != 0 || update_valid || expected_factor_q.size() != 0);
  endtask

  task automatic run_phase(input logic [FACTOR_PORT_W-1:0] max_value,
                           input logic [SHIFT_W-1:0] shift, input int idle_pct);
    write_register(REG_FACTOR_MAX, max_value);
    // junk in the upper bits must be dropped
    write_register(REG_SMOOTHING_SHIFT, ($urandom & ~32'hF) | CFG_DATA_W'(shift));
    @(negedge clk);
    idle_percent = idle_pct;
    repeat (PHASE_ITEMS) pending_window_q.push_back(make_window());
    drain();
  endtask

  // Driver: present queued items, hold while stalled, idle in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      update_valid <= 1'b0;
      send_gap     <= 0;
    end else begin
      if (update_valid && !update_stall) begin
        expected_factor_q.push_back(predict_factor(on_port));
      end
      if (!update_valid || !update_stall) begin
        if (send_gap > 0) begin
          update_valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (pending_window_q.size() != 0) begin
          on_port = pending_window_q.pop_front();
          sample_count        <= on_port.count;
          interval_sum        <= on_port.total;
          interval_square_sum <= on_port.squares;
          prior_factor        <= on_port.prior;
          update_valid        <= 1'b1;
          if (idle_percent > 0 && $urandom_range(0, 99) < idle_percent) begin
            send_gap <= $urandom_range(1, 11);
          end
        end else begin
          update_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_factor_q.size() == 0) begin
          report_mismatch("result with no item outstanding", new_factor, '0);
        end else begin
          wanted_factor = expected_factor_q.pop_front();
          if (new_factor !== wanted_factor) begin
            report_mismatch("factor mismatch", new_factor, wanted_factor);
          end
        end
        result_count++;
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left   <= stall_left - 1;
      end else if (idle_percent > 0 && $urandom_range(0, 99) < idle_percent / 3) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 10);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed items under the reset register values
    add_window('0, '0, '0, '0);
    add_window('0, '1, '1, '1);                  // no samples: prior passes, above clamp
    add_window(32'd1, '0, '0, '0);               // zero sum: raw is the clamp
    add_window('1, '0, '1, '1);
    add_window(32'd4, 32'd40, 64'd400, 32'd5000); // ratio exactly one
    add_window(32'd1, 32'd10, 64'd50, 32'd777);   // ratio below one
    add_window(32'd2, 32'd1, 64'd1, '0);
    add_window('1, '1, '1, '0);                  // quotient far above the clamp
    add_window(32'd1, 32'd1, '1, 32'd123);
    add_window(32'd5, 32'd7, '0, 32'd1000);      // falling average, no remainder
    add_window(32'd5, 32'd7, '0, 32'd1001);      // falling average, rounded down
    add_window(32'd3, 32'd3, 64'd5, 32'd43690);  // raw equals prior
    add_window(32'd16, 32'd32, 64'd65536, 32'd1);
    add_window(32'd17, 32'd1, 64'd1, 32'd2);     // raw lands on the clamp
    add_window(32'd16, 32'd1, 64'd1, 32'd3);
    add_window(32'd9, 32'd3, 64'd40, FACTOR_MAX_RESET);
    add_window(32'hAAAA_AAAA, 32'h5555_5555, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    add_window(32'h5555_5555, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    drain();

    run_phase(FACTOR_MAX_RESET, '0, 15);
    run_phase('1, 4'd15, 30);
    run_phase('0, SHIFT_W'($urandom_range(0, 15)), 10);
    // a write to an unmapped index must change nothing
    write_register(CFG_INDEX_W'($urandom_range(REG_SPARE_LO, (1 << CFG_INDEX_W) - 1)), $urandom);
    run_phase($urandom, SHIFT_W'($urandom_range(0, 15)), 20);
    run_phase($urandom_range(1 << 16, 1 << 19), SHIFT_W'($urandom_range(0, 15)), 0);
    run_phase('1, 4'd1, 25);
    run_phase(FACTOR_MAX_RESET, SHIFT_RESET, 0);

    repeat (PIPE_LATENCY + 40) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
